@@ rtl/core/mpba_pkg.sv @@
// shared constants, codes and types of the multi-pool block allocator
package mpba_pkg;

  localparam int unsigned PoolCount     = 4;
  localparam int unsigned BlocksPerPool = 16;
  localparam int unsigned SizeRegs      = 4;

  localparam int unsigned SizeW    = 16;
  localparam int unsigned PiuW     = 3;
  localparam int unsigned FPoolW   = 2;
  localparam int unsigned FBlockW  = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned PoolW    = $clog2(PoolCount);
  localparam int unsigned PoolIdxW = $clog2(PoolCount + 1);
  localparam int unsigned BlkW     = $clog2(BlocksPerPool);
  localparam int unsigned LinkW    = $clog2(BlocksPerPool + 1);
  localparam int unsigned SizeSelW = $clog2(SizeRegs);
  localparam int unsigned TotalBlk = PoolCount * BlocksPerPool;
  localparam int unsigned AddrW    = $clog2(TotalBlk);

  localparam logic [LinkW-1:0] NullLink = LinkW'(BlocksPerPool);

  // transaction modes
  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegSizeA     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSizeB     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSizeC     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSizeD     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPoolsUsed = 3'd4;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [LinkW-1:0] data;
  } link_wr_t;

endpackage

@@ rtl/core/mpba_req_if.sv @@
// request channel of the allocator
interface mpba_req_if import mpba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [SizeW-1:0]   request_size;
  logic [FPoolW-1:0]  free_pool;
  logic [FBlockW-1:0] free_block;

  modport source (output valid, mode, request_size, free_pool, free_block, input ready);
  modport sink   (input valid, mode, request_size, free_pool, free_block, output ready);
endinterface

@@ rtl/core/mpba_rsp_if.sv @@
// response channel of the allocator
interface mpba_rsp_if import mpba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               granted;
  logic [FPoolW-1:0]  given_pool;
  logic [FBlockW-1:0] given_block;

  modport source (output valid, granted, given_pool, given_block, input ready);
  modport sink   (input valid, granted, given_pool, given_block, output ready);
endinterface

@@ rtl/core/mpba_link_store.sv @@
// next-link memory of all free lists with per-entry valid bits for the reset chain
module mpba_link_store import mpba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  link_wr_t         wr_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [LinkW-1:0] rd_link_o
);

  logic [LinkW-1:0] mem [TotalBlk];
  logic [TotalBlk-1:0] valid_q;
  logic [LinkW-1:0] rd_data_q;
  logic             rd_valid_q;
  logic [BlkW-1:0]  rd_blk_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
      rd_blk_q  <= rd_addr_i[BlkW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // unwritten entry links to the following block, the last one to null
  assign rd_link_o = rd_valid_q ? rd_data_q
                                : LinkW'({1'b0, rd_blk_q}) + LinkW'(1);

endmodule

@@ rtl/core/multi_pool_block_allocator_top.sv @@
// top level of the multi-pool fixed-block allocator
// A free transaction is taken, pushed onto its pool's list in StFree and answered
// from StDone, after which the request side is ready again.
// An allocate transaction tests one pool per cycle with a single size comparator,
// then reads the popped block's link from the link memory in StRead, and the request
// side is ready again once the response is loaded in StDone.
// When none fits, every searched pool is tested and a final StSearch step closes the
// search; the pools searched are pools_in_use saturated at 4. A waiting response is
// held in the output register; the block stalls only when a new response is due before
// the previous one is taken. No work is needed after reset.
module multi_pool_block_allocator_top import mpba_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  mpba_req_if.sink            req_i,
  mpba_rsp_if.source          rsp_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSearch = 3'd1;
  localparam logic [2:0] StRead   = 3'd2;
  localparam logic [2:0] StFree   = 3'd3;
  localparam logic [2:0] StDone   = 3'd4;

  logic [2:0] state_q, state_d;

  logic [SizeW-1:0] size_reg_q [SizeRegs];
  logic [PiuW-1:0]  pools_in_use_q;

  logic [LinkW-1:0] list_head_q [PoolCount];

  logic               mode_q;
  logic [SizeW-1:0]   req_size_q;
  logic [FPoolW-1:0]  fpool_q;
  logic [FBlockW-1:0] fblock_q;

  logic [PoolIdxW-1:0] pool_q, pool_d;
  logic [BlkW-1:0]     blk_q, blk_d;
  logic                res_granted_q, res_granted_d;

  logic               out_valid_q, out_valid_d;
  logic               out_granted_q;
  logic [FPoolW-1:0]  out_pool_q;
  logic [FBlockW-1:0] out_block_q;

  logic                req_accept;
  logic [PoolIdxW-1:0] pools_searched;
  logic [SizeW-1:0]    cur_size;
  logic [LinkW-1:0]    cur_head;
  logic                size_fits;
  logic                pool_hit;
  logic                search_end;
  logic                free_ok;
  logic                out_load;
  link_wr_t            link_wr;
  logic                link_rd_en;
  logic [AddrW-1:0]    link_rd_addr;
  logic [LinkW-1:0]    link_rd;

  assign req_accept = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == StIdle);

  assign pools_searched = (pools_in_use_q > PiuW'(PoolCount)) ? PoolIdxW'(PoolCount)
                                                              : PoolIdxW'(pools_in_use_q);

  // shared compare unit: one pool per cycle
  assign cur_size  = (pool_q < PoolIdxW'(SizeRegs)) ? size_reg_q[pool_q[SizeSelW-1:0]] : '0;
  assign cur_head  = list_head_q[pool_q[PoolW-1:0]];
  assign size_fits = (cur_size >= req_size_q);
  assign search_end = (pool_q >= pools_searched);
  assign pool_hit  = !search_end && size_fits && (cur_head < NullLink);

  assign free_ok = (PoolIdxW'(fpool_q) < PoolIdxW'(PoolCount))
                && (LinkW'(fblock_q) < NullLink);

  assign link_rd_en   = (state_q == StSearch) && pool_hit;
  assign link_rd_addr = {pool_q[PoolW-1:0], cur_head[BlkW-1:0]};

  always_comb begin
    link_wr.en   = (state_q == StFree) && free_ok;
    link_wr.addr = {fpool_q[PoolW-1:0], fblock_q[BlkW-1:0]};
    link_wr.data = list_head_q[fpool_q[PoolW-1:0]];
  end

  mpba_link_store u_link_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (link_wr),
    .rd_en_i   (link_rd_en),
    .rd_addr_i (link_rd_addr),
    .rd_link_o (link_rd)
  );

  assign out_load = (state_q == StDone) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d       = state_q;
    pool_d        = pool_q;
    blk_d         = blk_q;
    res_granted_d = res_granted_q;
    case (state_q)
      StIdle: begin
        if (req_accept) begin
          pool_d        = '0;
          blk_d         = '0;
          res_granted_d = 1'b0;
          state_d       = (req_i.mode == ModeFree) ? StFree : StSearch;
        end
      end
      StSearch: begin
        if (search_end) begin
          pool_d  = '0;
          state_d = StDone;
        end else if (pool_hit) begin
          blk_d   = cur_head[BlkW-1:0];
          state_d = StRead;
        end else begin
          pool_d = pool_q + PoolIdxW'(1);
        end
      end
      StRead: begin
        res_granted_d = 1'b1;
        state_d       = StDone;
      end
      StFree: begin
        res_granted_d = free_ok;
        state_d       = StDone;
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      out_valid_q    <= 1'b0;
      size_reg_q[0]  <= 16'd16;
      size_reg_q[1]  <= 16'd32;
      size_reg_q[2]  <= 16'd64;
      size_reg_q[3]  <= 16'd128;
      pools_in_use_q <= 3'd4;
      for (int p = 0; p < PoolCount; p++) begin
        list_head_q[p] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegSizeA:     size_reg_q[0] <= cfg_data_i;
          RegSizeB:     size_reg_q[1] <= cfg_data_i;
          RegSizeC:     size_reg_q[2] <= cfg_data_i;
          RegSizeD:     size_reg_q[3] <= cfg_data_i;
          RegPoolsUsed: pools_in_use_q <= cfg_data_i[PiuW-1:0];
          default: ;
        endcase
      end
      if (link_wr.en) begin
        list_head_q[fpool_q[PoolW-1:0]] <= LinkW'(fblock_q);
      end
      if (state_q == StRead) begin
        list_head_q[pool_q[PoolW-1:0]] <= link_rd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      mode_q     <= req_i.mode;
      req_size_q <= req_i.request_size;
      fpool_q    <= req_i.free_pool;
      fblock_q   <= req_i.free_block;
    end
    pool_q        <= pool_d;
    blk_q         <= blk_d;
    res_granted_q <= res_granted_d;
    if (out_load) begin
      out_granted_q <= res_granted_q;
      out_pool_q    <= (mode_q == ModeAlloc && res_granted_q) ? FPoolW'(pool_q) : '0;
      out_block_q   <= (mode_q == ModeAlloc && res_granted_q) ? FBlockW'(blk_q) : '0;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.granted     = out_granted_q;
  assign rsp_o.given_pool  = out_pool_q;
  assign rsp_o.given_block = out_block_q;

  ap_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |=> (state_q == StSearch || state_q == StFree))
    else $error("accepted transaction did not start work");

  ap_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> (pool_q < pools_searched && $past(link_rd_en)))
    else $error("link read without a matching pool hit");

  ap_fail_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.granted) |-> (rsp_o.given_pool == '0 && rsp_o.given_block == '0))
    else $error("failed response carries a block");

  ap_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && out_valid_q && !rsp_o.ready) |=> (state_q == StDone))
    else $error("response dropped while output stalled");

endmodule
